>>> hdl/mhmd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhmd_pkg: shared types and constants for the multiply/divide unit
// Holds the command codes and the item record passed between stages.
// ---------------------------------------------------------------------------
package mhmd_pkg;

    localparam int WordW = 32;

    typedef enum logic [1:0] {
        CMD_MULT  = 2'd0,
        CMD_MULTU = 2'd1,
        CMD_DIV   = 2'd2,
        CMD_DIVU  = 2'd3
    } cmd_t;

    // Classified item: operand magnitudes plus sign and special-case flags.
    typedef struct packed {
        logic             is_div;
        logic             special;
        logic [WordW-1:0] sp_hi;
        logic [WordW-1:0] sp_lo;
        logic [WordW-1:0] mag_a;
        logic [WordW-1:0] mag_b;
        logic             neg_q;
        logic             neg_r;
    } item_t;

endpackage
`default_nettype wire

>>> hdl/mips_hilo_mul_div_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mips_hilo_mul_div_unit: HI/LO multiply and divide unit
// Top level joining the decode front end and the arithmetic pipe.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one beat per operation: a command (signed or
//   unsigned multiply or divide) and two 32-bit operands. The m_ channel
//   returns one beat per operation with the HI and LO words, in order.
//   Multiply gives the 64-bit product; divide gives quotient in LO and
//   remainder in HI. Divide by zero gives the dividend in HI and all ones
//   (1 for a negative signed dividend) in LO; MIN / -1 gives fixed words.
//   The decode register loads at the accepting edge, then the item walks a
//   34-stage pipe set by the radix-2 divider, one quotient bit per divide
//   stage. Throughput is one operation per cycle when the receiver does not
//   stall.
//   Reset empties the pipe. When the receiver stalls the pipe holds, an
//   empty decode register takes one more beat, and then s_ready drops.
// ---------------------------------------------------------------------------
module mips_hilo_mul_div_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [31:0] s_operand_a,
    input  wire logic [31:0] s_operand_b,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_hi_word,
    output logic [31:0]      m_lo_word
);
    logic            f_valid, f_ready;
    mhmd_pkg::item_t f_item;

    mhmd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .f_valid(f_valid), .f_ready(f_ready), .f_item(f_item)
    );

    mhmd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .f_valid(f_valid), .f_ready(f_ready), .f_item(f_item),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hi_word(m_hi_word), .m_lo_word(m_lo_word)
    );
endmodule
`default_nettype wire

>>> hdl/mhmd_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhmd_front: command decode and operand conditioning
// Registers one classified item; takes magnitudes and flags special cases.
// ---------------------------------------------------------------------------
module mhmd_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_command,
    input  wire logic [31:0]              s_operand_a,
    input  wire logic [31:0]              s_operand_b,
    output logic                          f_valid,
    input  wire logic                     f_ready,
    output mhmd_pkg::item_t               f_item
);
    logic            valid_reg;
    mhmd_pkg::item_t item_reg, item_next;
    logic            sgn, na, nb;

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    always_comb begin
        sgn = (s_command == mhmd_pkg::CMD_MULT) || (s_command == mhmd_pkg::CMD_DIV);
        na  = sgn && s_operand_a[31];
        nb  = sgn && s_operand_b[31];
        item_next.is_div  = s_command[1];
        item_next.mag_a   = na ? 32'(0 - s_operand_a) : s_operand_a;
        item_next.mag_b   = nb ? 32'(0 - s_operand_b) : s_operand_b;
        item_next.neg_q   = na ^ nb;
        item_next.neg_r   = na;
        item_next.special = 1'b0;
        item_next.sp_hi   = s_operand_a;
        item_next.sp_lo   = na ? 32'd1 : 32'hFFFF_FFFF;
        if (s_command[1] && s_operand_b == 32'd0) begin
            item_next.special = 1'b1;
        end else if (s_command == mhmd_pkg::CMD_DIV && s_operand_a == 32'h8000_0000
                     && s_operand_b == 32'hFFFF_FFFF) begin
            item_next.special = 1'b1;
            item_next.sp_hi   = 32'd0;
            item_next.sp_lo   = 32'h8000_0000;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            item_reg <= item_next;
        end
    end
endmodule
`default_nettype wire

>>> hdl/mhmd_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhmd_back: pipelined multiply and radix-2 divide
// One quotient bit per stage over 32 stages; the multiply rides alongside,
// split into four 16x16 partial products. The whole pipe stalls together.
// ---------------------------------------------------------------------------
module mhmd_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        f_valid,
    output logic             f_ready,
    input  mhmd_pkg::item_t  f_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_hi_word,
    output logic [31:0]      m_lo_word
);
    localparam int Stages = 34;

    typedef struct packed {
        mhmd_pkg::item_t it;
        logic [31:0]     rem;
        logic [31:0]     quo;
        logic [63:0]     prod;
    } stage_t;

    logic   [Stages-1:0] v_reg;
    stage_t              st_reg [Stages];
    stage_t              st_next [Stages];
    logic                adv;
    logic [32:0]         trial;
    logic [31:0]         ph, pl;

    assign adv     = !v_reg[Stages-1] || m_ready;
    assign f_ready = adv;
    assign m_valid = v_reg[Stages-1];

    always_comb begin
        // Stage 0: the two aligned 16x16 partial products; cross products follow in stage 1.
        st_next[0].it   = f_item;
        st_next[0].rem  = '0;
        st_next[0].quo  = f_item.mag_a;
        st_next[0].prod = {32'(f_item.mag_a[31:16] * f_item.mag_b[31:16]),
                           32'(f_item.mag_a[15:0] * f_item.mag_b[15:0])};
        // Stash cross products in rem/quo is not possible for divide, so add
        // them in the next stage from the stored magnitudes.
        for (int i = 1; i < Stages; i++) begin
            st_next[i] = st_reg[i-1];
        end
        ph = 32'(st_reg[0].it.mag_a[31:16] * st_reg[0].it.mag_b[15:0]);
        pl = 32'(st_reg[0].it.mag_a[15:0] * st_reg[0].it.mag_b[31:16]);
        st_next[1].prod = st_reg[0].prod + {16'd0, ph, 16'd0} + {16'd0, pl, 16'd0};
        // Stages 1..32: one restoring divide step each.
        for (int i = 1; i <= 32; i++) begin
            trial = {st_reg[i-1].rem, st_reg[i-1].quo[31]} - {1'b0, st_reg[i-1].it.mag_b};
            if (!trial[32]) begin
                st_next[i].rem = trial[31:0];
                st_next[i].quo = {st_reg[i-1].quo[30:0], 1'b1};
            end else begin
                st_next[i].rem = {st_reg[i-1].rem[30:0], st_reg[i-1].quo[31]};
                st_next[i].quo = {st_reg[i-1].quo[30:0], 1'b0};
            end
        end
        // Final stage: sign fix-up and result selection.
        st_next[Stages-1] = st_reg[Stages-2];
        if (st_reg[Stages-2].it.special) begin
            st_next[Stages-1].rem = st_reg[Stages-2].it.sp_hi;
            st_next[Stages-1].quo = st_reg[Stages-2].it.sp_lo;
        end else if (st_reg[Stages-2].it.is_div) begin
            st_next[Stages-1].rem = st_reg[Stages-2].it.neg_r ?
                32'(0 - st_reg[Stages-2].rem) : st_reg[Stages-2].rem;
            st_next[Stages-1].quo = st_reg[Stages-2].it.neg_q ?
                32'(0 - st_reg[Stages-2].quo) : st_reg[Stages-2].quo;
        end else begin
            {st_next[Stages-1].rem, st_next[Stages-1].quo} = st_reg[Stages-2].it.neg_q ?
                64'(0 - st_reg[Stages-2].prod) : st_reg[Stages-2].prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[Stages-2:0], f_valid};
        end
        if (adv) begin
            for (int i = 0; i < Stages; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign m_hi_word = st_reg[Stages-1].rem;
    assign m_lo_word = st_reg[Stages-1].quo;
endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for mips_hilo_mul_div_unit
// Drives multiply and divide operations with random bursts and gaps, stalls
// the result channel on its own pattern, and compares each HI/LO beat with
// a local prediction of the operation.
// ---------------------------------------------------------------------------
module tb;

    typedef struct {
        mhmd_pkg::cmd_t cmd;
        logic [31:0]    a;
        logic [31:0]    b;
    } op_t;

    typedef struct {
        logic [31:0] hi;
        logic [31:0] lo;
    } hilo_t;

    localparam int unsigned CycleLimit = 200000;
    localparam int          Latency    = 35;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [31:0] s_operand_a;
    logic [31:0] s_operand_b;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_hi_word;
    logic [31:0] m_lo_word;

    op_t         pending_ops[$];
    hilo_t       expected_hilo[$];
    int          errors;
    int unsigned cycle_count;
    int          burst_left;
    int          gap_left;
    int          stall_phase;
    bit          hold_off;

    mips_hilo_mul_div_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hi_word(m_hi_word), .m_lo_word(m_lo_word)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic hilo_t compute_hilo(op_t op);
        hilo_t       r;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] p;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] rem;
        bit          na;
        bit          nb;
        na = op.a[31];
        nb = op.b[31];
        case (op.cmd)
            mhmd_pkg::CMD_MULT, mhmd_pkg::CMD_MULTU: begin
                x = {32'd0, op.a};
                y = {32'd0, op.b};
                if (op.cmd == mhmd_pkg::CMD_MULT) begin
                    if (na) x[63:32] = '1;
                    if (nb) y[63:32] = '1;
                end
                p = x * y;
                r.hi = p[63:32];
                r.lo = p[31:0];
            end
            mhmd_pkg::CMD_DIVU: begin
                if (op.b == 0) begin
                    r.hi = op.a;
                    r.lo = 32'hFFFF_FFFF;
                end else begin
                    r.lo = op.a / op.b;
                    r.hi = op.a % op.b;
                end
            end
            default: begin
                if (op.b == 0) begin
                    r.hi = op.a;
                    r.lo = na ? 32'd1 : 32'hFFFF_FFFF;
                end else if (op.a == 32'h8000_0000 && op.b == 32'hFFFF_FFFF) begin
                    r.hi = 32'd0;
                    r.lo = 32'h8000_0000;
                end else begin
                    ma = na ? -op.a : op.a;
                    mb = nb ? -op.b : op.b;
                    q = ma / mb;
                    rem = ma % mb;
                    r.lo = (na != nb) ? -q : q;
                    r.hi = na ? -rem : rem;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 16);
            5: return -$urandom_range(1, 16);
            6: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(mhmd_pkg::cmd_t c, logic [31:0] a, logic [31:0] b);
        op_t op;
        op.cmd = c;
        op.a = a;
        op.b = b;
        pending_ops.push_back(op);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_command <= '0;
            s_operand_a <= '0;
            s_operand_b <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_hilo.push_back(compute_hilo(
                    '{mhmd_pkg::cmd_t'(s_command), s_operand_a, s_operand_b}));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_ops.size() > 0 && !hold_off) begin
                    s_valid <= 1'b1;
                    s_command <= pending_ops[0].cmd;
                    s_operand_a <= pending_ops[0].a;
                    s_operand_b <= pending_ops[0].b;
                    void'(pending_ops.pop_front());
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls follow a slowly drifting pattern with stall-free stretches.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase >> 7) % 4)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= (stall_phase % 5) < 2;
                default: m_ready <= ($urandom_range(0, 1) == 1);
            endcase
            if (m_valid && m_ready) begin
                if (expected_hilo.size() == 0) begin
                    $display("%0t: unexpected result hi=%h lo=%h", $time, m_hi_word,
                             m_lo_word);
                    errors <= errors + 1;
                end else begin
                    if (m_hi_word !== expected_hilo[0].hi) begin
                        $display("%0t: hi_word expected %h actual %h", $time,
                                 expected_hilo[0].hi, m_hi_word);
                    end
                    if (m_lo_word !== expected_hilo[0].lo) begin
                        $display("%0t: lo_word expected %h actual %h", $time,
                                 expected_hilo[0].lo, m_lo_word);
                    end
                    if (m_hi_word !== expected_hilo[0].hi ||
                        m_lo_word !== expected_hilo[0].lo) begin
                        errors <= errors + 1;
                    end
                    void'(expected_hilo.pop_front());
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("mips_hilo_mul_div_unit test failed");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = '0;
        s_operand_a = '0;
        s_operand_b = '0;
        m_ready = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: operand extremes, every command, divide faults.
        queue_op(mhmd_pkg::CMD_MULT, 32'h8000_0000, 32'h8000_0000);
        queue_op(mhmd_pkg::CMD_MULT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        queue_op(mhmd_pkg::CMD_MULT, 32'd0, 32'hFFFF_FFFF);
        queue_op(mhmd_pkg::CMD_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(mhmd_pkg::CMD_MULTU, 32'h8000_0000, 32'd2);
        queue_op(mhmd_pkg::CMD_MULTU, 32'd0, 32'd0);
        queue_op(mhmd_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(mhmd_pkg::CMD_DIV, 32'h8000_0000, 32'd0);
        queue_op(mhmd_pkg::CMD_DIV, 32'd7, 32'd0);
        queue_op(mhmd_pkg::CMD_DIV, 32'd0, 32'd0);
        queue_op(mhmd_pkg::CMD_DIV, -32'd7, 32'd2);
        queue_op(mhmd_pkg::CMD_DIV, 32'd7, -32'd2);
        queue_op(mhmd_pkg::CMD_DIV, -32'd7, -32'd2);
        queue_op(mhmd_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'd1);
        queue_op(mhmd_pkg::CMD_DIV, 32'h8000_0000, 32'h8000_0000);
        queue_op(mhmd_pkg::CMD_DIVU, 32'hFFFF_FFFF, 32'd0);
        queue_op(mhmd_pkg::CMD_DIVU, 32'hFFFF_FFFF, 32'd1);
        queue_op(mhmd_pkg::CMD_DIVU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(mhmd_pkg::CMD_DIVU, 32'd5, 32'hFFFF_FFFF);
        queue_op(mhmd_pkg::CMD_DIVU, 32'h8000_0000, 32'd3);

        // Let the directed beats drain completely before the random part.
        wait (pending_ops.size() == 0);
        hold_off = 1'b1;
        wait (!s_valid && expected_hilo.size() == 0);
        hold_off = 1'b0;

        for (int i = 0; i < 430; i++) begin
            queue_op(mhmd_pkg::cmd_t'($urandom_range(0, 3)), rand_word(), rand_word());
        end

        wait (pending_ops.size() == 0);
        wait (!s_valid && expected_hilo.size() == 0);
        repeat (Latency + 10) @(posedge aclk);
        if (errors == 0) begin
            $display("mips_hilo_mul_div_unit test passed");
        end else begin
            $display("mips_hilo_mul_div_unit test failed");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/mhmd_pkg.sv
hdl/mhmd_front.sv
hdl/mhmd_back.sv
hdl/mips_hilo_mul_div_unit.sv
sim/tb.sv
